@@ design/iirdf2_pkg.sv @@
// Shared types and constants for the direct form II IIR filter.
// Used by iirdf2_mac and iir_direct_form_two_filter; depends on nothing else.
package iirdf2_pkg;

  // Filter size and number formats
  localparam int ORDER          = 2;
  localparam int SAMPLE_BITS    = 24;
  localparam int COEF_BITS      = 32;
  localparam int COEF_FRAC_BITS = 28;
  localparam int STATE_BITS     = 40;
  localparam int WFRAC          = STATE_BITS - SAMPLE_BITS - 8;
  localparam int ORDER_BITS     = 2;

  // Shared multiplier: coefficient times one 33-bit slice of a 40-bit delay value
  localparam int SLICE_BITS = 32;
  localparam int OPND_BITS  = SLICE_BITS + 1;
  localparam int PROD_BITS  = COEF_BITS + OPND_BITS;
  localparam int ACC_BITS   = COEF_BITS + STATE_BITS + 4;

  // Sequencer step counts: two partial products per tap
  localparam int FB_STEPS = 2 * ORDER;
  localparam int FF_STEPS = 2 * (ORDER + 1);
  localparam int STEP_W   = $clog2(FF_STEPS);
  localparam int TAP_W    = $clog2(ORDER + 1);
  localparam int DLY_W    = (ORDER > 1) ? $clog2(ORDER) : 1;

  // Configuration port
  localparam int ADDR_BITS = 5;
  localparam int DATA_BITS = 32;
  localparam int REG_IDX_W = 3;

  localparam logic [REG_IDX_W-1:0] REG_NUM_COEF_0     = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_NUM_COEF_1     = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_NUM_COEF_2     = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_DEN_COEF_1     = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_DEN_COEF_2     = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_NUM_ORDER_USED = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_DEN_ORDER_USED = 3'd6;

  localparam logic [COEF_BITS-1:0]  NUM_COEF_0_RESET = 32'h1000_0000;
  localparam logic [ORDER_BITS-1:0] ORDER_MAX        = ORDER_BITS'(ORDER);

  // Input command codes
  localparam logic CMD_FILTER = 1'b0;
  localparam logic CMD_CLEAR  = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FB,
    ST_FB_DRAIN,
    ST_W_ROUND,
    ST_FF,
    ST_FF_DRAIN,
    ST_Y_ROUND
  } state_e;

  // Control from the sequencer to the multiply-accumulate unit
  typedef struct packed {
    logic issue;     // start one partial product
    logic hi_part;   // product belongs 32 bits up
    logic subtract;  // subtract instead of add
    logic load;      // overwrite the accumulator
  } mac_ctrl_t;

endpackage

@@ design/iirdf2_mac.sv @@
// Shared multiply-accumulate unit of the IIR filter: one 32x33 multiplier,
// a product register and a wide accumulator. Depends on iirdf2_pkg.
module iirdf2_mac (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  iirdf2_pkg::mac_ctrl_t                   ctrl_i,
  input  logic signed [iirdf2_pkg::COEF_BITS-1:0] coef_i,
  input  logic signed [iirdf2_pkg::OPND_BITS-1:0] opnd_i,
  input  logic signed [iirdf2_pkg::ACC_BITS-1:0]  load_val_i,
  output logic signed [iirdf2_pkg::ACC_BITS-1:0]  acc_o
);

  logic signed [iirdf2_pkg::PROD_BITS-1:0] prod_q;
  logic                                    prod_vld_q;
  logic                                    prod_hi_q;
  logic                                    prod_sub_q;
  logic signed [iirdf2_pkg::ACC_BITS-1:0]  acc_q, acc_d;
  logic signed [iirdf2_pkg::ACC_BITS-1:0]  term;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.issue) begin
      prod_q <= coef_i * opnd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_vld_q <= 1'b0;
      prod_hi_q  <= 1'b0;
      prod_sub_q <= 1'b0;
    end else begin
      prod_vld_q <= ctrl_i.issue;
      prod_hi_q  <= ctrl_i.hi_part;
      prod_sub_q <= ctrl_i.subtract;
    end
  end

  // Align the registered product and fold it into the accumulator in the cycle after issue
  always_comb begin
    term = {{(iirdf2_pkg::ACC_BITS - iirdf2_pkg::PROD_BITS){prod_q[iirdf2_pkg::PROD_BITS-1]}},
            prod_q};
    if (prod_hi_q) begin
      term = term <<< iirdf2_pkg::SLICE_BITS;
    end
    acc_d = acc_q;
    if (ctrl_i.load) begin
      acc_d = load_val_i;
    end else if (prod_vld_q) begin
      acc_d = prod_sub_q ? (acc_q - term) : (acc_q + term);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else begin
      acc_q <= acc_d;
    end
  end

  assign acc_o = acc_q;

endmodule

@@ design/iir_direct_form_two_filter.sv @@
// Direct form II IIR biquad: sequencer, coefficient registers, delay line, output beat.
// A filter beat steps ST_FB, ST_FB_DRAIN, ST_W_ROUND, ST_FF, ST_FF_DRAIN, ST_Y_ROUND;
// a clear beat only zeroes the delay line. A new sample is taken only in ST_IDLE, as the
// shared 32x33 multiplier does ten partial products (two per coefficient) plus rounding.
// Reset (rst_ni low, asynchronous): delay line zero, b0 = 1.0, other coefficients zero,
// both order registers at 2, no result pending. Depends on iirdf2_pkg and iirdf2_mac.
module iir_direct_form_two_filter (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  // Input stream
  input  logic                                   s_axis_tvalid,
  output logic                                   s_axis_tready,
  input  logic [iirdf2_pkg::SAMPLE_BITS-1:0]     s_axis_tdata,   // [23:0] sample_in
  input  logic                                   s_axis_tuser,   // [0] command
  input  logic                                   s_axis_tlast,   // block_end_in
  // Output stream
  output logic                                   m_axis_tvalid,
  input  logic                                   m_axis_tready,
  output logic [iirdf2_pkg::SAMPLE_BITS-1:0]     m_axis_tdata,   // [23:0] sample_out
  output logic                                   m_axis_tlast,   // block_end_out
  // Configuration port
  input  logic                                   psel,
  input  logic                                   penable,
  input  logic                                   pwrite,
  input  logic [iirdf2_pkg::ADDR_BITS-1:0]       paddr,
  input  logic [iirdf2_pkg::DATA_BITS-1:0]       pwdata,
  output logic [iirdf2_pkg::DATA_BITS-1:0]       prdata,
  output logic                                   pready
);

  localparam int AccW  = iirdf2_pkg::ACC_BITS;
  localparam int SmpW  = iirdf2_pkg::SAMPLE_BITS;
  localparam int StW   = iirdf2_pkg::STATE_BITS;
  localparam int CoefW = iirdf2_pkg::COEF_BITS;
  localparam int WShift = iirdf2_pkg::COEF_FRAC_BITS;
  localparam int YShift = iirdf2_pkg::WFRAC + iirdf2_pkg::COEF_FRAC_BITS;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic signed [CoefW-1:0]                  num_coef_q [iirdf2_pkg::ORDER+1];
  logic signed [CoefW-1:0]                  den_coef_q [iirdf2_pkg::ORDER];  // a1 at index 0
  logic [iirdf2_pkg::ORDER_BITS-1:0]        num_order_q;
  logic [iirdf2_pkg::ORDER_BITS-1:0]        den_order_q;
  logic                                     cfg_wr;
  logic [iirdf2_pkg::REG_IDX_W-1:0]         cfg_idx;
  logic [iirdf2_pkg::ORDER_BITS-1:0]        order_wr;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign cfg_idx = paddr[iirdf2_pkg::ADDR_BITS-1:2];

  // Clamp an order write to the largest supported tap
  assign order_wr = (pwdata[iirdf2_pkg::ORDER_BITS-1:0] > iirdf2_pkg::ORDER_MAX) ?
                    iirdf2_pkg::ORDER_MAX : pwdata[iirdf2_pkg::ORDER_BITS-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_coef_q[0] <= iirdf2_pkg::NUM_COEF_0_RESET;
      num_coef_q[1] <= '0;
      num_coef_q[2] <= '0;
      den_coef_q[0] <= '0;
      den_coef_q[1] <= '0;
      num_order_q   <= iirdf2_pkg::ORDER_MAX;
      den_order_q   <= iirdf2_pkg::ORDER_MAX;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        iirdf2_pkg::REG_NUM_COEF_0:     num_coef_q[0] <= pwdata;
        iirdf2_pkg::REG_NUM_COEF_1:     num_coef_q[1] <= pwdata;
        iirdf2_pkg::REG_NUM_COEF_2:     num_coef_q[2] <= pwdata;
        iirdf2_pkg::REG_DEN_COEF_1:     den_coef_q[0] <= pwdata;
        iirdf2_pkg::REG_DEN_COEF_2:     den_coef_q[1] <= pwdata;
        iirdf2_pkg::REG_NUM_ORDER_USED: num_order_q   <= order_wr;
        iirdf2_pkg::REG_DEN_ORDER_USED: den_order_q   <= order_wr;
        default: ;  // drop writes past the register list
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      iirdf2_pkg::REG_NUM_COEF_0:     prdata = num_coef_q[0];
      iirdf2_pkg::REG_NUM_COEF_1:     prdata = num_coef_q[1];
      iirdf2_pkg::REG_NUM_COEF_2:     prdata = num_coef_q[2];
      iirdf2_pkg::REG_DEN_COEF_1:     prdata = den_coef_q[0];
      iirdf2_pkg::REG_DEN_COEF_2:     prdata = den_coef_q[1];
      iirdf2_pkg::REG_NUM_ORDER_USED:
        prdata = {{(iirdf2_pkg::DATA_BITS - iirdf2_pkg::ORDER_BITS){1'b0}}, num_order_q};
      iirdf2_pkg::REG_DEN_ORDER_USED:
        prdata = {{(iirdf2_pkg::DATA_BITS - iirdf2_pkg::ORDER_BITS){1'b0}}, den_order_q};
      default: prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  iirdf2_pkg::state_e                state_q, state_d;
  logic [iirdf2_pkg::STEP_W-1:0]     step_q, step_d;
  logic                              in_beat;
  logic                              out_free;
  logic                              fb_last;
  logic                              ff_last;

  assign in_beat  = s_axis_tvalid & s_axis_tready;
  assign out_free = ~m_axis_tvalid | m_axis_tready;
  assign fb_last  = (step_q == iirdf2_pkg::STEP_W'(iirdf2_pkg::FB_STEPS - 1));
  assign ff_last  = (step_q == iirdf2_pkg::STEP_W'(iirdf2_pkg::FF_STEPS - 1));

  // Next state
  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    unique case (state_q)
      iirdf2_pkg::ST_IDLE: begin
        step_d = '0;
        if (in_beat && (s_axis_tuser == iirdf2_pkg::CMD_FILTER)) begin
          state_d = iirdf2_pkg::ST_FB;
        end
      end
      iirdf2_pkg::ST_FB: begin
        step_d = step_q + 1'b1;
        if (fb_last) begin
          state_d = iirdf2_pkg::ST_FB_DRAIN;
        end
      end
      iirdf2_pkg::ST_FB_DRAIN: state_d = iirdf2_pkg::ST_W_ROUND;
      iirdf2_pkg::ST_W_ROUND: begin
        step_d  = '0;
        state_d = iirdf2_pkg::ST_FF;
      end
      iirdf2_pkg::ST_FF: begin
        step_d = step_q + 1'b1;
        if (ff_last) begin
          state_d = iirdf2_pkg::ST_FF_DRAIN;
        end
      end
      iirdf2_pkg::ST_FF_DRAIN: state_d = iirdf2_pkg::ST_Y_ROUND;
      iirdf2_pkg::ST_Y_ROUND: begin
        if (out_free) begin
          state_d = iirdf2_pkg::ST_IDLE;
        end
      end
      default: state_d = iirdf2_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= iirdf2_pkg::ST_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Operand selection: step bit 0 picks the low or high slice, the rest the tap
  // ---------------------------------------------------------------------------
  logic signed [StW-1:0]             dly_q [iirdf2_pkg::ORDER];
  logic signed [StW-1:0]             w0_q;
  logic                              blk_end_q;
  logic [iirdf2_pkg::TAP_W-1:0]      tap;
  logic [iirdf2_pkg::TAP_W-1:0]      tap_m1;
  logic signed [StW-1:0]             w_sel;
  logic signed [CoefW-1:0]           coef_sel;
  logic signed [iirdf2_pkg::OPND_BITS-1:0] opnd_sel;
  logic signed [AccW-1:0]            load_val;
  logic signed [AccW-1:0]            acc;
  iirdf2_pkg::mac_ctrl_t             mac_ctrl;

  assign tap    = step_q[iirdf2_pkg::STEP_W-1:1];
  assign tap_m1 = tap - 1'b1;

  always_comb begin
    w_sel    = dly_q[tap[iirdf2_pkg::DLY_W-1:0]];
    coef_sel = '0;
    if (state_q == iirdf2_pkg::ST_FF) begin
      // feed-forward: b0 against w0, b_i against w_i
      w_sel = (tap == '0) ? w0_q : dly_q[tap_m1[iirdf2_pkg::DLY_W-1:0]];
      if (tap <= num_order_q) begin
        coef_sel = num_coef_q[tap];
      end
    end else begin
      // feedback: a_(tap+1) against w_(tap+1); unused taps multiply by zero
      if ((tap + 1'b1) <= den_order_q) begin
        coef_sel = den_coef_q[tap[iirdf2_pkg::DLY_W-1:0]];
      end
    end
    if (step_q[0]) begin
      opnd_sel = {{(iirdf2_pkg::OPND_BITS - (StW - iirdf2_pkg::SLICE_BITS)){w_sel[StW-1]}},
                  w_sel[StW-1:iirdf2_pkg::SLICE_BITS]};
    end else begin
      opnd_sel = {1'b0, w_sel[iirdf2_pkg::SLICE_BITS-1:0]};
    end
  end

  // Outputs of the sequencer
  always_comb begin
    mac_ctrl          = '0;
    mac_ctrl.hi_part  = step_q[0];
    mac_ctrl.subtract = (state_q == iirdf2_pkg::ST_FB);
    load_val          = '0;
    unique case (state_q)
      iirdf2_pkg::ST_IDLE: begin
        // seed the accumulator with x aligned to the product scale
        mac_ctrl.load = in_beat && (s_axis_tuser == iirdf2_pkg::CMD_FILTER);
        load_val = {{(AccW - SmpW){s_axis_tdata[SmpW-1]}}, s_axis_tdata} <<< YShift;
      end
      iirdf2_pkg::ST_FB, iirdf2_pkg::ST_FF: mac_ctrl.issue = 1'b1;
      iirdf2_pkg::ST_W_ROUND: mac_ctrl.load = 1'b1;  // restart for the numerator sum
      default: ;
    endcase
  end

  assign s_axis_tready = (state_q == iirdf2_pkg::ST_IDLE);

  iirdf2_mac u_mac (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (mac_ctrl),
    .coef_i     (coef_sel),
    .opnd_i     (opnd_sel),
    .load_val_i (load_val),
    .acc_o      (acc)
  );

  // ---------------------------------------------------------------------------
  // Rounding: add half an LSB, shift arithmetically, saturate
  // ---------------------------------------------------------------------------
  logic signed [AccW-1:0] w_rnd, w_shf;
  logic signed [AccW-1:0] y_rnd, y_shf;
  logic signed [StW-1:0]  w0_d;
  logic signed [SmpW-1:0] y_d;
  logic                   w_fits;
  logic                   y_fits;

  always_comb begin
    w_rnd  = acc + (AccW'(1) <<< (WShift - 1));
    w_shf  = w_rnd >>> WShift;
    w_fits = (&w_shf[AccW-1:StW-1]) | ~(|w_shf[AccW-1:StW-1]);
    if (w_fits) begin
      w0_d = w_shf[StW-1:0];
    end else begin
      w0_d = w_shf[AccW-1] ? {1'b1, {(StW-1){1'b0}}} : {1'b0, {(StW-1){1'b1}}};
    end

    y_rnd  = acc + (AccW'(1) <<< (YShift - 1));
    y_shf  = y_rnd >>> YShift;
    y_fits = (&y_shf[AccW-1:SmpW-1]) | ~(|y_shf[AccW-1:SmpW-1]);
    if (y_fits) begin
      y_d = y_shf[SmpW-1:0];
    end else begin
      y_d = y_shf[AccW-1] ? {1'b1, {(SmpW-1){1'b0}}} : {1'b0, {(SmpW-1){1'b1}}};
    end
  end

  // ---------------------------------------------------------------------------
  // Delay line, w0 hold and block-end capture
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (in_beat) begin
      blk_end_q <= s_axis_tlast;
    end
    if (state_q == iirdf2_pkg::ST_W_ROUND) begin
      w0_q <= w0_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < iirdf2_pkg::ORDER; i++) begin
        dly_q[i] <= '0;
      end
    end else if (in_beat && (s_axis_tuser == iirdf2_pkg::CMD_CLEAR)) begin
      for (int i = 0; i < iirdf2_pkg::ORDER; i++) begin
        dly_q[i] <= '0;
      end
    end else if ((state_q == iirdf2_pkg::ST_Y_ROUND) && out_free) begin
      // advance the delay line as the result enters the output register
      for (int i = iirdf2_pkg::ORDER - 1; i > 0; i--) begin
        dly_q[i] <= dly_q[i-1];
      end
      dly_q[0] <= w0_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Output register: hold the beat until the sink takes it
  // ---------------------------------------------------------------------------
  logic               out_vld_q;
  logic [SmpW-1:0]    out_data_q;
  logic               out_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if ((state_q == iirdf2_pkg::ST_Y_ROUND) && out_free) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == iirdf2_pkg::ST_Y_ROUND) && out_free) begin
      out_data_q <= y_d;
      out_last_q <= blk_end_q;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tlast  = out_last_q;

endmodule
